[hdl/wpi_pkg.sv]
// Shared types, constants and codes for the wheel pulse interpolator.
`timescale 1ns / 1ps
package wpi_pkg;

    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int NUM_WHEELS = 4;
    localparam int WHL_W      = $clog2(NUM_WHEELS);
    localparam int CNT_W      = 16;
    localparam int WRAP_W     = 8;
    localparam int LAG_W      = 4;
    localparam int DIV_W      = 36;
    localparam int DEN_W      = CNT_W + 4;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [CNT_W-1:0] STEP_LIMIT_RST = 16'd600;
    localparam logic [CNT_W-1:0] ROLL_LIMIT_RST = 16'd8;
    localparam logic [LAG_W-1:0] LAG_RST        = 4'd4;

    localparam logic [1:0] CFG_ROLL_EN    = 2'd0;
    localparam logic [1:0] CFG_STEP_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ROLL_LIMIT = 2'd2;
    localparam logic [1:0] CFG_LAG        = 2'd3;

    localparam logic REQ_STORE  = 1'b0;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        AV_INIT  = 2'd0,
        AV_ERROR = 2'd1,
        AV_READY = 2'd2
    } avail_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_ROLL,
        LN_SCAN,
        LN_RD1,
        LN_RD2,
        LN_CHK,
        LN_MUL,
        LN_D1S,
        LN_D1W,
        LN_SUM,
        ST_FAIL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             req_type;
        logic [CNT_W-1:0] stamp;
        logic [CNT_W-1:0] count_w0;
        logic [CNT_W-1:0] count_w1;
        logic [CNT_W-1:0] count_w2;
        logic [CNT_W-1:0] count_w3;
    } in_t;

    typedef struct packed {
        logic              status;
        logic [CNT_W-1:0]  lin_w0;
        logic [CNT_W-1:0]  lin_w1;
        logic [CNT_W-1:0]  lin_w2;
        logic [CNT_W-1:0]  lin_w3;
        logic [WRAP_W-1:0] wraps_w0;
        logic [WRAP_W-1:0] wraps_w1;
        logic [WRAP_W-1:0] wraps_w2;
        logic [WRAP_W-1:0] wraps_w3;
        logic              renew_ref;
        logic [1:0]        avail;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

endpackage

[hdl/wheel_pulse_interpolator.sv]
// Top level: sample ring, roll detection and linearize sequencer for four wheels.
`timescale 1ns / 1ps
// Store transaction: writes with the previous entry in hand and reads the lag entry, then
//   does the roll update, then loads the result register; the next accept waits for idle.
// Linearize: scan of every ring entry, fetch the pair and check steps, then for each wheel
//   multiply, one 36-step pass of the shared serial divider, sum; the divider is skipped if
//   the pair shares a timestamp, and the result is an error if no sample or a step is too big.
// One transaction at a time; s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous): ring valid bits cleared so every entry reads zero,
//   pointers and wrap counters zero, registers back to their defaults.
module wheel_pulse_interpolator (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  wpi_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output wpi_pkg::out_t             m_data,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_idx,
    input  logic [wpi_pkg::CNT_W-1:0] cfg_data
);
    localparam int P = wpi_pkg::PTR_W;
    localparam int C = wpi_pkg::CNT_W;
    localparam int R = wpi_pkg::WRAP_W;
    localparam int N = wpi_pkg::NUM_WHEELS;

    typedef logic [N-1:0][C-1:0] cnts_t;
    typedef logic [N-1:0][R-1:0] wraps_t;

    // config
    logic                       roll_en_reg;
    logic [C-1:0]               step_limit_reg;
    logic [C-1:0]               roll_limit_reg;
    logic [wpi_pkg::LAG_W-1:0]  lag_reg;

    // control state
    wpi_pkg::state_t state_reg, state_next;
    wpi_pkg::avail_t avail_reg;
    logic [P-1:0]    wp_reg;
    logic [P-1:0]    pos_reg;
    wraps_t          wrap_now_reg;
    wraps_t          wrap_seen_reg;
    logic [C-1:0]    roll_ref_reg;
    logic [C-1:0]    roll_count_reg;
    logic            stop_reg;
    logic            standing_reg;
    logic            m_valid_reg;
    wpi_pkg::out_t   m_data_reg;

    // ring memories, one read port shared by address, valid bit per row
    logic [C-1:0]          mem_stamp [wpi_pkg::RING_DEPTH];
    cnts_t                 mem_count [wpi_pkg::RING_DEPTH];
    wraps_t                mem_wraps [wpi_pkg::RING_DEPTH];
    logic [wpi_pkg::RING_DEPTH-1:0] vld_reg;
    logic [P-1:0]          rd_addr;
    logic [C-1:0]          rd_stamp_reg;
    cnts_t                 rd_count_reg;
    wraps_t                rd_wraps_reg;
    logic                  rd_vld_reg;
    logic [C-1:0]          rd_stamp;
    cnts_t                 rd_count;
    wraps_t                rd_wraps;
    logic                  wr_en;
    wraps_t                wr_wraps;

    // transaction data
    wpi_pkg::in_t in_reg;
    cnts_t        cnt_in;
    logic [P:0]   scan_reg;
    logic         found_reg;
    logic [C-1:0] best_reg;
    logic [P-1:0] i1_reg;
    cnts_t        c1_reg;
    wraps_t       wr1_reg;
    wraps_t       wr2_reg;
    cnts_t        dc_reg;
    logic [C-1:0] dt_reg;
    logic [C-1:0] trf_reg;
    logic [wpi_pkg::WHL_W-1:0] w_reg;
    logic [2*C-1:0]            prod_reg;
    logic [C-1:0]              inc_reg;
    cnts_t                     res_lin_reg;
    wraps_t                    res_wrap_reg;
    logic                      res_status_reg;
    logic                      res_renew_reg;

    wpi_pkg::div_req_t div_req;
    wpi_pkg::div_rsp_t div_rsp;

    // datapath helpers
    logic              first_store;
    wraps_t            wrap_new;
    logic [C-1:0]      tick;
    logic              take;
    logic [P-1:0]      scan_idx;
    cnts_t             dc_now;
    logic              step_err;
    logic [wpi_pkg::DIV_W-1:0] prod_x10;
    logic [wpi_pkg::DIV_W-1:0] dt_x5;
    logic [wpi_pkg::DEN_W-1:0] dt_x10;
    logic [C-1:0]      lin_now;
    logic [R-1:0]      src_wrap;

    wpi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready = (state_reg == wpi_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign cnt_in = {in_reg.count_w3, in_reg.count_w2, in_reg.count_w1, in_reg.count_w0};

    // entries never written read as zero
    assign rd_stamp = rd_vld_reg ? rd_stamp_reg : '0;
    assign rd_count = rd_vld_reg ? rd_count_reg : '0;
    assign rd_wraps = rd_vld_reg ? rd_wraps_reg : '0;

    assign first_store = (avail_reg == wpi_pkg::AV_INIT);
    always_comb begin
        for (int w = 0; w < N; w++) begin
            wrap_new[w] = wrap_now_reg[w] + R'(cnt_in[w] < rd_count[w]);
            dc_now[w]   = rd_count[w] - c1_reg[w];
        end
    end
    assign wr_wraps = first_store ? '0 : wrap_new;

    // a lag of zero compares the new entry with itself
    assign tick = (lag_reg == '0) ? '0 : (in_reg.count_w0 - rd_count[0]);

    assign scan_idx = scan_reg[P-1:0] - 1'b1;
    assign take = (scan_reg != '0) && (rd_stamp < in_reg.stamp) &&
                  (!found_reg || (rd_stamp > best_reg));

    always_comb begin
        step_err = 1'b0;
        for (int w = 0; w < N; w++) begin
            if (dc_now[w] > step_limit_reg) begin
                step_err = 1'b1;
            end
        end
    end

    // rounded (10*dc*trf/dt + 5)/10 in one pass: (10*dc*trf + 5*dt) / (10*dt)
    assign prod_x10 = {1'b0, prod_reg, 3'b000} + {3'b000, prod_reg, 1'b0};
    assign dt_x5    = {{(wpi_pkg::DIV_W-C-2){1'b0}}, dt_reg, 2'b00} +
                      {{(wpi_pkg::DIV_W-C){1'b0}}, dt_reg};
    assign dt_x10   = {1'b0, dt_reg, 3'b000} + {3'b000, dt_reg, 1'b0};
    assign lin_now  = c1_reg[w_reg] + inc_reg;
    assign src_wrap = (lin_now < c1_reg[w_reg]) ? wr2_reg[w_reg] : wr1_reg[w_reg];

    // sequencer
    always_comb begin
        state_next  = state_reg;
        rd_addr     = wp_reg - 1'b1;
        wr_en       = 1'b0;
        div_req     = '0;
        div_req.num = prod_x10 + dt_x5;
        div_req.den = dt_x10;
        unique case (state_reg)
            wpi_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.req_type == wpi_pkg::REQ_STORE) ?
                                 wpi_pkg::ST_WRITE : wpi_pkg::LN_SCAN;
                end
            end
            wpi_pkg::ST_WRITE: begin
                wr_en      = 1'b1;
                rd_addr    = pos_reg - lag_reg;
                state_next = wpi_pkg::ST_ROLL;
            end
            wpi_pkg::ST_ROLL: state_next = wpi_pkg::ST_DONE;
            wpi_pkg::LN_SCAN: begin
                rd_addr = scan_reg[P-1:0];
                if (scan_reg == (P+1)'(wpi_pkg::RING_DEPTH)) begin
                    state_next = (found_reg || take) ? wpi_pkg::LN_RD1 : wpi_pkg::ST_FAIL;
                end
            end
            wpi_pkg::LN_RD1: begin
                rd_addr    = i1_reg;
                state_next = wpi_pkg::LN_RD2;
            end
            wpi_pkg::LN_RD2: begin
                rd_addr    = i1_reg + 1'b1;
                state_next = wpi_pkg::LN_CHK;
            end
            wpi_pkg::LN_CHK: state_next = step_err ? wpi_pkg::ST_FAIL : wpi_pkg::LN_MUL;
            wpi_pkg::LN_MUL: state_next = (dt_reg == '0) ? wpi_pkg::LN_SUM : wpi_pkg::LN_D1S;
            wpi_pkg::LN_D1S: begin
                div_req.start = 1'b1;
                state_next    = wpi_pkg::LN_D1W;
            end
            wpi_pkg::LN_D1W: if (div_rsp.done) state_next = wpi_pkg::LN_SUM;
            wpi_pkg::LN_SUM: begin
                state_next = (w_reg == wpi_pkg::WHL_W'(N - 1)) ?
                             wpi_pkg::ST_DONE : wpi_pkg::LN_MUL;
            end
            wpi_pkg::ST_FAIL: state_next = wpi_pkg::ST_DONE;
            wpi_pkg::ST_DONE: if (!m_valid_reg || m_ready) state_next = wpi_pkg::ST_IDLE;
            default: state_next = wpi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wpi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ring memory ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_stamp[pos_reg] <= in_reg.stamp;
            mem_count[pos_reg] <= cnt_in;
            mem_wraps[pos_reg] <= wr_wraps;
        end
        rd_stamp_reg <= mem_stamp[rd_addr];
        rd_count_reg <= mem_count[rd_addr];
        rd_wraps_reg <= mem_wraps[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (wr_en) begin
                vld_reg[pos_reg] <= 1'b1;
            end
        end
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_en_reg    <= 1'b0;
            step_limit_reg <= wpi_pkg::STEP_LIMIT_RST;
            roll_limit_reg <= wpi_pkg::ROLL_LIMIT_RST;
            lag_reg        <= wpi_pkg::LAG_RST;
            avail_reg      <= wpi_pkg::AV_INIT;
            wp_reg         <= '0;
            wrap_now_reg   <= '0;
            wrap_seen_reg  <= '0;
            roll_ref_reg   <= '0;
            roll_count_reg <= '0;
            stop_reg       <= 1'b0;
            standing_reg   <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_ready && (state_reg != wpi_pkg::ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_idx)
                    wpi_pkg::CFG_ROLL_EN: begin
                        roll_en_reg <= cfg_data[0];
                        if (!cfg_data[0]) begin
                            stop_reg       <= 1'b0;
                            roll_count_reg <= '0;
                        end
                    end
                    wpi_pkg::CFG_STEP_LIMIT: step_limit_reg <= cfg_data;
                    wpi_pkg::CFG_ROLL_LIMIT: roll_limit_reg <= cfg_data;
                    wpi_pkg::CFG_LAG:        lag_reg <= cfg_data[wpi_pkg::LAG_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                wpi_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        in_reg         <= s_data;
                        pos_reg        <= wp_reg;
                        scan_reg       <= '0;
                        found_reg      <= 1'b0;
                        w_reg          <= '0;
                        res_lin_reg    <= '0;
                        res_wrap_reg   <= '0;
                        res_status_reg <= wpi_pkg::STATUS_OK;
                        res_renew_reg  <= 1'b0;
                    end
                end
                wpi_pkg::ST_WRITE: begin
                    if (first_store) begin
                        avail_reg <= wpi_pkg::AV_ERROR;
                    end else begin
                        wrap_now_reg <= wrap_new;
                    end
                end
                wpi_pkg::ST_ROLL: begin
                    wp_reg <= pos_reg + 1'b1;
                    if (roll_en_reg) begin
                        standing_reg <= (tick == '0);
                        if (stop_reg || ((tick == '0) && !standing_reg)) begin
                            roll_ref_reg <= in_reg.count_w0;
                        end
                        if (stop_reg) begin
                            if ((tick == '0) && ((roll_count_reg +
                                (in_reg.count_w0 - roll_ref_reg)) > roll_limit_reg)) begin
                                res_renew_reg  <= 1'b1;
                                roll_count_reg <= '0;
                            end else begin
                                roll_count_reg <= roll_count_reg +
                                                  (in_reg.count_w0 - roll_ref_reg);
                            end
                        end else if (tick == '0) begin
                            stop_reg <= 1'b1;
                        end
                    end
                end
                wpi_pkg::LN_SCAN: begin
                    scan_reg <= scan_reg + 1'b1;
                    if (take) begin
                        found_reg <= 1'b1;
                        best_reg  <= rd_stamp;
                        i1_reg    <= scan_idx;
                    end
                end
                wpi_pkg::LN_RD2: begin
                    c1_reg  <= rd_count;
                    wr1_reg <= rd_wraps;
                end
                wpi_pkg::LN_CHK: begin
                    dc_reg  <= dc_now;
                    wr2_reg <= rd_wraps;
                    dt_reg  <= rd_stamp - best_reg;
                    trf_reg <= in_reg.stamp - best_reg;
                end
                wpi_pkg::LN_MUL: begin
                    prod_reg <= dc_reg[w_reg] * trf_reg;
                    inc_reg  <= '0;
                end
                wpi_pkg::LN_D1W: if (div_rsp.done) inc_reg <= div_rsp.quo[C-1:0];
                wpi_pkg::LN_SUM: begin
                    res_lin_reg[w_reg]   <= lin_now;
                    res_wrap_reg[w_reg]  <= src_wrap - wrap_seen_reg[w_reg];
                    wrap_seen_reg[w_reg] <= src_wrap;
                    w_reg                <= w_reg + 1'b1;
                    if (w_reg == wpi_pkg::WHL_W'(N - 1)) begin
                        avail_reg <= wpi_pkg::AV_READY;
                    end
                end
                wpi_pkg::ST_FAIL: begin
                    avail_reg      <= wpi_pkg::AV_ERROR;
                    res_status_reg <= wpi_pkg::STATUS_ERR;
                end
                wpi_pkg::ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg          <= 1'b1;
                        m_data_reg.status    <= res_status_reg;
                        m_data_reg.lin_w0    <= res_lin_reg[0];
                        m_data_reg.lin_w1    <= res_lin_reg[1];
                        m_data_reg.lin_w2    <= res_lin_reg[2];
                        m_data_reg.lin_w3    <= res_lin_reg[3];
                        m_data_reg.wraps_w0  <= res_wrap_reg[0];
                        m_data_reg.wraps_w1  <= res_wrap_reg[1];
                        m_data_reg.wraps_w2  <= res_wrap_reg[2];
                        m_data_reg.wraps_w3  <= res_wrap_reg[3];
                        m_data_reg.renew_ref <= res_renew_reg;
                        m_data_reg.avail     <= avail_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // once a transaction is taken the sequencer is busy next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // a nonzero interpolated count only comes from a successful linearize
    a_avail_not_init: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == wpi_pkg::STATUS_OK && m_data.renew_ref == 1'b0 &&
        m_data.lin_w0 != '0 |-> m_data.avail == wpi_pkg::AV_READY)
        else $error("interpolated count without available data");

    // error results carry no wheel 0 count or wraps and report an error availability
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == wpi_pkg::STATUS_ERR |->
        m_data.lin_w0 == '0 && m_data.wraps_w0 == '0 && m_data.avail == wpi_pkg::AV_ERROR)
        else $error("error result with payload");

endmodule

[hdl/wpi_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle while busy.
`timescale 1ns / 1ps
module wpi_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  wpi_pkg::div_req_t req,
    output wpi_pkg::div_rsp_t rsp
);
    logic [wpi_pkg::DEN_W-1:0]     rem_reg;
    logic [wpi_pkg::DIV_W-1:0]     quo_reg;
    logic [wpi_pkg::DEN_W-1:0]     den_reg;
    logic [wpi_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [wpi_pkg::DEN_W:0]       trial;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[wpi_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.num;
                den_reg  <= req.den;
            end else if (busy_reg) begin
                rem_reg <= fits ? wpi_pkg::DEN_W'(trial - {1'b0, den_reg})
                                : trial[wpi_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[wpi_pkg::DIV_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == wpi_pkg::DIV_CNT_W'(wpi_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
